### rtl/core/assert_macros.svh
// assertion macros used by the checker module
// each macro expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define SLT_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, off while in reset
`define SLT_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/core/slt_pkg.sv
// shared types and constants of the sorted list table
// no dependencies
package slt_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W        = 32;
	localparam int POS_W         = 8;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int COUNT_OUT_W   = 5;

	// command codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	localparam logic signed [DATA_W-1:0] NOT_FOUND_VALUE = -32'sd999;

	// what one cell shows its neighbors
	typedef struct packed {
		logic              le;
		logic              lt;
		logic [DATA_W-1:0] entry;
	} link_t;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic                     cmp_en;
		logic signed [DATA_W-1:0] cmp_value;
		logic [POS_W-1:0]         cmp_pos;
		logic                     ins_en;
		logic                     rem_en;
		logic signed [DATA_W-1:0] ins_value;
	} cell_ctl_t;

endpackage

### rtl/core/sorted_list_table.sv
// sorted list table top level: command pipeline, cell chain, response register
// depends on slt_pkg and slt_cell
//
// Keeps up to DEPTH signed 32-bit values in ascending order in a chain of
// cells, one entry per cell. In a request's first stage every cell compares its
// entry with the request value or position; in its second each cell keeps its
// entry, takes the new value or takes a neighbor's entry, and the response is
// written to the output register. The second stage waits while the previous
// response is not taken. A new request is taken once the last one has left the
// first stage and the second can go on, whatever DEPTH is. The read value and
// the remove hit are gathered by an OR across the cells. Reset clears the count
// and valid flags, not the entries; entry_count shows the count's low five bits.
module sorted_list_table #(
	parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  logic [slt_pkg::OP_W-1:0]            opcode,
	input  logic signed [slt_pkg::DATA_W-1:0]   value,
	input  logic [slt_pkg::POS_W-1:0]           position,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [slt_pkg::STATUS_W-1:0]        status,
	output logic signed [slt_pkg::DATA_W-1:0]   result_value,
	output logic [slt_pkg::COUNT_OUT_W-1:0]     entry_count
);

	localparam int COUNT_W = $clog2(DEPTH + 1);

	logic                                valid_s1, valid_s2;
	logic [slt_pkg::OP_W-1:0]            op_s1, op_s2;
	logic signed [slt_pkg::DATA_W-1:0]   value_s1, value_s2;
	logic [slt_pkg::POS_W-1:0]           pos_s1;
	logic [COUNT_W-1:0]                  count_q, count_next;
	logic                                out_valid_q;
	logic [slt_pkg::STATUS_W-1:0]        status_q, status_next;
	logic signed [slt_pkg::DATA_W-1:0]   result_q, result_next;
	logic [slt_pkg::COUNT_OUT_W-1:0]     entry_count_q;

	logic cmd_accept, s2_fire, full, found, read_hit;
	logic [slt_pkg::DATA_W-1:0] rd_any;

	slt_pkg::cell_ctl_t ctl;
	slt_pkg::link_t     links [DEPTH];
	logic [DEPTH-1:0]   hits, sels;
	logic [slt_pkg::DATA_W-1:0] rd_values [DEPTH];

	// handshake
	assign s2_fire    = valid_s2 && (!out_valid_q || rsp_ready);
	assign cmd_ready  = !valid_s1 && (!valid_s2 || s2_fire);
	assign cmd_accept = cmd_valid && cmd_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			valid_s1 <= cmd_accept;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_fire) begin
				valid_s2 <= 1'b0;
			end
			if (s2_fire) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload through the two stages
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			op_s1    <= opcode;
			value_s1 <= value;
			pos_s1   <= position;
		end
		if (valid_s1) begin
			op_s2    <= op_s1;
			value_s2 <= value_s1;
		end
		if (s2_fire) begin
			status_q      <= status_next;
			result_q      <= result_next;
			entry_count_q <= slt_pkg::COUNT_OUT_W'(count_next);
		end
	end

	// gather hits and read data across the chain
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_any = rd_any | rd_values[i];
		end
	end
	assign found    = |hits;
	assign read_hit = |sels;
	assign full     = count_q == COUNT_W'(DEPTH);

	// response and next count
	always_comb begin
		status_next = slt_pkg::ST_OK;
		result_next = '0;
		count_next  = count_q;
		unique case (op_s2)
			slt_pkg::OP_INSERT: begin
				if (full) begin
					status_next = slt_pkg::ST_FULL;
				end else begin
					count_next = count_q + 1'b1;
				end
			end
			slt_pkg::OP_REMOVE: begin
				if (found) begin
					count_next = count_q - 1'b1;
				end else begin
					status_next = slt_pkg::ST_NOT_FOUND;
				end
			end
			slt_pkg::OP_READ: begin
				if (read_hit) begin
					result_next = $signed(rd_any);
				end else begin
					status_next = slt_pkg::ST_NOT_FOUND;
					result_next = slt_pkg::NOT_FOUND_VALUE;
				end
			end
			default: begin
				status_next = slt_pkg::ST_OK;
			end
		endcase
	end

	// broadcast to the cells
	assign ctl.cmp_en    = valid_s1;
	assign ctl.cmp_value = value_s1;
	assign ctl.cmp_pos   = pos_s1;
	assign ctl.ins_en    = s2_fire && (op_s2 == slt_pkg::OP_INSERT) && !full;
	assign ctl.rem_en    = s2_fire && (op_s2 == slt_pkg::OP_REMOVE) && found;
	assign ctl.ins_value = value_s2;

	// the chain
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		slt_pkg::link_t             left_link;
		logic [slt_pkg::DATA_W-1:0] right_entry;

		if (g == 0) begin : g_head
			assign left_link = '{le: 1'b1, lt: 1'b1, entry: '0};
		end else begin : g_body
			assign left_link = links[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign right_entry = links[g].entry;
		end else begin : g_mid
			assign right_entry = links[g+1].entry;
		end

		slt_cell #(
			.INDEX   (g),
			.COUNT_W (COUNT_W)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.left        (left_link),
			.right_entry (right_entry),
			.link        (links[g]),
			.hit         (hits[g]),
			.sel         (sels[g]),
			.rd_value    (rd_values[g])
		);
	end

	assign rsp_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign entry_count  = entry_count_q;

endmodule

### rtl/core/slt_cell.sv
// one slot of the sorted chain: holds an entry, compares it, shifts it
// depends on slt_pkg
module slt_cell #(
	parameter int INDEX   = 0,
	parameter int COUNT_W = 5
) (
	input  logic                   clk,
	input  slt_pkg::cell_ctl_t     ctl,
	input  logic [COUNT_W-1:0]     count,
	input  slt_pkg::link_t         left,
	input  logic [slt_pkg::DATA_W-1:0] right_entry,
	output slt_pkg::link_t         link,
	output logic                   hit,
	output logic                   sel,
	output logic [slt_pkg::DATA_W-1:0] rd_value
);

	logic [slt_pkg::DATA_W-1:0] entry_q;
	logic le_q, lt_q, eq_q, sel_q;
	logic occupied;

	// slot holds a live entry
	assign occupied = count > COUNT_W'(INDEX);

	// compare phase: flags against the broadcast value and position
	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			le_q  <= occupied && ($signed(entry_q) <= ctl.cmp_value);
			lt_q  <= occupied && ($signed(entry_q) < ctl.cmp_value);
			eq_q  <= occupied && ($signed(entry_q) == ctl.cmp_value);
			sel_q <= occupied && ({1'b0, ctl.cmp_pos} == 9'(INDEX + 1));
		end
	end

	// shift phase: open a gap for insert, close one for remove
	always_ff @(posedge clk) begin
		if (ctl.ins_en && !le_q) begin
			entry_q <= left.le ? ctl.ins_value : left.entry;
		end else if (ctl.rem_en && !lt_q) begin
			entry_q <= right_entry;
		end
	end

	assign link     = '{le: le_q, lt: lt_q, entry: entry_q};
	assign hit      = eq_q && left.lt;
	assign sel      = sel_q;
	assign rd_value = sel_q ? entry_q : '0;

endmodule

### rtl/core/slt_checker.sv
// port-level checks for the sorted list table, bound to the top level
// depends on slt_pkg and assert_macros.svh
`include "assert_macros.svh"

module slt_checker #(
	parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cmd_valid,
	input logic                                cmd_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [slt_pkg::STATUS_W-1:0]        status,
	input logic signed [slt_pkg::DATA_W-1:0]   result_value,
	input logic [slt_pkg::COUNT_OUT_W-1:0]     entry_count
);

	// a stalled response holds its payload
	`SLT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(status) && $stable(result_value) && $stable(entry_count))

	// no request taken right after one
	`SLT_ASSERT_NXT(a_one_in_flight, cmd_valid && cmd_ready, !cmd_ready)

	// a dropped insert only happens on a full table and carries zero
	`SLT_ASSERT_IMP(a_full_rsp, rsp_valid && (status == slt_pkg::ST_FULL),
		(result_value == '0) && (entry_count == slt_pkg::COUNT_OUT_W'(DEPTH)))

	// only the three defined status codes appear
	`SLT_ASSERT_IMP(a_status_code, rsp_valid,
		(status == slt_pkg::ST_OK) || (status == slt_pkg::ST_NOT_FOUND) ||
		(status == slt_pkg::ST_FULL))

endmodule

bind sorted_list_table slt_checker #(.DEPTH(DEPTH)) u_slt_checker (.*);

### tb/tb_top.sv
// self-checking testbench for the sorted list table: sorted insert, remove and read requests
// depends on slt_pkg and sorted_list_table
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = slt_pkg::DEPTH_DEFAULT;
	localparam logic [slt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1700;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 300;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [slt_pkg::OP_W-1:0]          op;
		logic signed [slt_pkg::DATA_W-1:0] val;
		logic [slt_pkg::POS_W-1:0]         pos;
		bit                                drain_first;
	} request_t;

	typedef struct {
		logic [slt_pkg::STATUS_W-1:0]      st;
		logic signed [slt_pkg::DATA_W-1:0] val;
		logic [slt_pkg::COUNT_OUT_W-1:0]   cnt;
	} answer_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cmd_valid = 1'b0;
	logic                                cmd_ready;
	logic [slt_pkg::OP_W-1:0]            opcode = '0;
	logic signed [slt_pkg::DATA_W-1:0]   value = '0;
	logic [slt_pkg::POS_W-1:0]           position = '0;
	logic                                rsp_valid;
	logic                                rsp_ready = 1'b0;
	logic [slt_pkg::STATUS_W-1:0]        status;
	logic signed [slt_pkg::DATA_W-1:0]   result_value;
	logic [slt_pkg::COUNT_OUT_W-1:0]     entry_count;

	// mirror of the table contents
	logic signed [slt_pkg::DATA_W-1:0] mirror_entries [0:TABLE_DEPTH-1];
	int                                mirror_count;

	request_t request_q[$];
	answer_t  answer_q[$];
	request_t on_wire;
	int       n_taken = 0;
	int       n_done = 0;
	int       faults = 0;
	int       quiet_cycles = 0;
	int       hold_left = 0;
	bit       long_hold_done = 1'b0;
	logic     calm;

	sorted_list_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.opcode       (opcode),
		.value        (value),
		.position     (position),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.result_value (result_value),
		.entry_count  (entry_count)
	);

	// no random idling on either side over this stretch of requests
	assign calm = (n_taken >= 900) && (n_taken < 1100);

	// apply one request to the mirror and return the answer it should give
	function automatic answer_t table_step(request_t r);
		answer_t a;
		int k;
		a.st = slt_pkg::ST_OK;
		a.val = '0;
		case (r.op)
			slt_pkg::OP_INSERT: begin
				if (mirror_count >= TABLE_DEPTH) begin
					a.st = slt_pkg::ST_FULL;
				end else begin
					// new value goes after every entry less than or equal to it
					k = 0;
					while (k < mirror_count && mirror_entries[k] <= r.val)
						k++;
					for (int i = mirror_count; i > k; i--)
						mirror_entries[i] = mirror_entries[i-1];
					mirror_entries[k] = r.val;
					mirror_count++;
				end
			end
			slt_pkg::OP_REMOVE: begin
				k = 0;
				while (k < mirror_count && mirror_entries[k] != r.val)
					k++;
				if (k >= mirror_count) begin
					a.st = slt_pkg::ST_NOT_FOUND;
				end else begin
					for (int i = k; i + 1 < mirror_count; i++)
						mirror_entries[i] = mirror_entries[i+1];
					mirror_count--;
				end
			end
			slt_pkg::OP_READ: begin
				if (r.pos == 0 || int'(r.pos) > mirror_count) begin
					a.st = slt_pkg::ST_NOT_FOUND;
					a.val = slt_pkg::NOT_FOUND_VALUE;
				end else begin
					a.val = mirror_entries[r.pos-1];
				end
			end
			default: ;
		endcase
		a.cnt = mirror_count[slt_pkg::COUNT_OUT_W-1:0];
		return a;
	endfunction

	function automatic request_t mk(logic [slt_pkg::OP_W-1:0] op,
			logic signed [slt_pkg::DATA_W-1:0] v, logic [slt_pkg::POS_W-1:0] p, bit drain);
		request_t r;
		r.op = op;
		r.val = v;
		r.pos = p;
		r.drain_first = drain;
		return r;
	endfunction

	task automatic note_fault(string msg);
		faults++;
		if (faults <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// reset, once at the start
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin : driver
		bit took;
		int busy;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			n_taken <= 0;
		end else begin
			took = cmd_valid && cmd_ready;
			if (took) begin
				answer_q.push_back(table_step(on_wire));
				n_taken <= n_taken + 1;
			end
			busy = n_taken + int'(took) - n_done;
			if (!cmd_valid || cmd_ready) begin
				if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 34)
						&& !(request_q[0].drain_first && busy != 0)) begin
					on_wire = request_q.pop_front();
					cmd_valid <= 1'b1;
					opcode <= on_wire.op;
					value <= on_wire.val;
					position <= on_wire.pos;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// response side ready, with one long hold-off once the run is under way
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (!long_hold_done && n_taken >= 400) begin
			long_hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= calm || ($urandom_range(0, 99) >= 34);
		end
	end

	// response monitor and checker
	always @(posedge clk) begin : monitor
		answer_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			n_done <= n_done + 1;
			if (answer_q.size() == 0) begin
				note_fault($sformatf("unexpected response: status %0d value %0d count %0d",
					status, result_value, entry_count));
			end else begin
				want = answer_q.pop_front();
				if (status !== want.st || result_value !== want.val
						|| entry_count !== want.cnt)
					note_fault($sformatf(
						"mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
						want.st, want.val, want.cnt, status, result_value, entry_count));
			end
		end
	end

	// watchdog on cycles with no request or response taken
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int recent[$];
		int n_gen;
		int mode;
		int len;
		int r;
		int pick;
		bit pause_done;
		logic [slt_pkg::OP_W-1:0] op;
		logic signed [slt_pkg::DATA_W-1:0] v;
		logic [slt_pkg::POS_W-1:0] p;
		bit drain;

		mirror_count = 0;

		// directed: empty table, extremes, duplicates, edges of position, full table
		request_q.push_back(mk(slt_pkg::OP_READ, 0, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_READ, 0, 8'd1, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_REMOVE, 5, 8'd0, 1'b0));
		request_q.push_back(mk(OP_UNUSED, -1, 8'hff, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_INSERT, 32'sh7fffffff, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_INSERT, 32'sh80000000, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_INSERT, 0, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_INSERT, 0, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_INSERT, -1, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_READ, 0, 8'd1, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_READ, 0, 8'd5, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_READ, 0, 8'd6, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_READ, 0, 8'd255, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_REMOVE, 0, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_REMOVE, 42, 8'd0, 1'b0));
		// fill the table, append at the end, then overflow it
		request_q.push_back(mk(slt_pkg::OP_INSERT, 32'sh7fffffff, 8'd0, 1'b0));
		for (int i = 0; i < 10; i++)
			request_q.push_back(mk(slt_pkg::OP_INSERT, $urandom, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_INSERT, -999, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_INSERT, 7, 8'd0, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_READ, 0, 8'd16, 1'b0));
		request_q.push_back(mk(slt_pkg::OP_READ, 0, 8'd17, 1'b0));

		// random bursts of fill, drain, mixed and noise traffic
		n_gen = 0;
		pause_done = 1'b0;
		while (n_gen < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(8, 40);
			drain = ($urandom_range(0, 7) == 0) || (!pause_done && n_gen >= 1200);
			if (n_gen >= 1200)
				pause_done = 1'b1;
			for (int j = 0; j < len; j++) begin
				r = $urandom_range(0, 99);
				case (mode)
					0: op = (r < 75) ? slt_pkg::OP_INSERT : (r < 85) ? slt_pkg::OP_READ
						: (r < 95) ? slt_pkg::OP_REMOVE : OP_UNUSED;
					1: op = (r < 60) ? slt_pkg::OP_REMOVE : (r < 75) ? slt_pkg::OP_INSERT
						: (r < 95) ? slt_pkg::OP_READ : OP_UNUSED;
					2: op = (r < 35) ? slt_pkg::OP_INSERT : (r < 65) ? slt_pkg::OP_REMOVE
						: (r < 95) ? slt_pkg::OP_READ : OP_UNUSED;
					default: op = slt_pkg::OP_W'($urandom_range(0, 3));
				endcase
				// value: small pool for collisions, wide, extremes or a recent insert
				pick = $urandom_range(0, 9);
				if (mode == 3 || (pick >= 4 && pick < 7))
					v = $urandom;
				else if (pick < 4)
					v = int'($urandom_range(0, 8)) - 4;
				else if (pick == 7 || recent.size() == 0)
					case ($urandom_range(0, 4))
						0: v = 32'sh7fffffff;
						1: v = 32'sh80000000;
						2: v = -999;
						3: v = -1;
						default: v = 0;
					endcase
				else
					v = recent[$urandom_range(0, recent.size() - 1)];
				if (op == slt_pkg::OP_REMOVE && recent.size() != 0
						&& $urandom_range(0, 9) < 7)
					v = recent[$urandom_range(0, recent.size() - 1)];
				if (op == slt_pkg::OP_INSERT) begin
					recent.push_back(v);
					if (recent.size() > 24)
						void'(recent.pop_front());
				end
				if ($urandom_range(0, 9) < 8)
					p = slt_pkg::POS_W'($urandom_range(0, 18));
				else
					p = slt_pkg::POS_W'($urandom_range(0, 255));
				request_q.push_back(mk(op, v, p, drain && j == 0));
				n_gen++;
			end
		end

		// wait for the last request, then for every response
		@(negedge clk);
		while (request_q.size() != 0 || cmd_valid)
			@(negedge clk);
		while (n_taken != n_done)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (faults == 0 && answer_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
